### src/fhcpd_pkg.sv
// Shared types and constants for the four-header CR LF packet deframer.
// No dependencies.
`timescale 1ns / 1ps

package fhcpd_pkg;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    localparam logic [7:0] HDR_A_RST   = 8'd64;
    localparam logic [7:0] HDR_B_RST   = 8'd35;
    localparam logic [7:0] HDR_C_RST   = 8'd36;
    localparam logic [7:0] HDR_D_RST   = 8'd37;
    localparam logic [4:0] MAX_LEN_RST = 5'd19;

    localparam logic [CFG_ADDR_W-1:0] REG_HDR_A   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_B   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_C   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HDR_D   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN = 3'd4;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // payload store write request: first restarts the store at entry zero
    typedef struct packed {
        logic       we;
        logic       first;
        logic [7:0] data;
    } t_wr_req;

    // completed packet handed from the parser to the drain side
    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [4:0] len;
    } t_job;

endpackage

### src/four_header_crlf_packet_deframer_unit.sv
// Four-header CR LF packet deframer, top level.
// Depends on fhcpd_pkg, fhcpd_front, fhcpd_back.
//
// Takes one request per cycle: a received byte or the release of one kind's
// ready flag. The parser writes body bytes into a BUFFER_DEPTH-entry payload
// store; on the LF that closes a packet it posts the packet to the drain side
// and stops taking requests until the drain has issued its last store read,
// which comes later when the output is held off. Results leave at one per
// cycle while the output takes them, paced by the single read port of the
// store, from an output register, so the input reopens while the last
// results are still waiting to be taken. An empty packet gives one result
// flagged empty. The store needs no clearing after reset.
`timescale 1ns / 1ps

module four_header_crlf_packet_deframer_unit #(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [fhcpd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fhcpd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] rx_byte, [9:8] release_kind, [15:10] zero
    input  logic [fhcpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] packet_kind, [9:2] payload_byte, [14:10] byte_index,
    // [19:15] packet_length, [23:20] zero
    output logic [fhcpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] empty_packet
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import fhcpd_pkg::*;

    t_wr_req    wr;
    t_job       job;
    logic       busy;
    logic [1:0] kind;
    logic [7:0] pbyte;
    logic [4:0] idx;
    logic [4:0] len;

    fhcpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_rel_kind  (s_axis_tdata[9:8]),
        .i_busy      (busy),
        .o_wr        (wr),
        .o_job       (job)
    );

    fhcpd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_job   (job),
        .o_busy  (busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (kind),
        .o_byte  (pbyte),
        .o_idx   (idx),
        .o_len   (len),
        .o_empty (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, len, idx, pbyte, kind};

endmodule

### src/fhcpd_front.sv
// Parser front end: accepts bytes and release requests, holds the config
// registers and ready flags, writes payload bytes and posts completed packets.
// Depends on fhcpd_pkg.
`timescale 1ns / 1ps

module fhcpd_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [fhcpd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [fhcpd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [7:0]                       i_byte,
    input  logic [1:0]                       i_rel_kind,
    input  logic                             i_busy,
    output fhcpd_pkg::t_wr_req               o_wr,
    output fhcpd_pkg::t_job                  o_job
);
    import fhcpd_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;

    logic [7:0] r_hdr [4];
    logic [4:0] r_max_len;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_kind,  n_kind;
    logic [4:0] r_wpos,  n_wpos;
    logic [3:0] r_flags, n_flags;

    logic       accept;
    logic       hit;
    logic [1:0] hit_kind;

    assign o_ready = !i_busy;
    assign accept  = i_valid && !i_busy;

    // lowest kind wins when header characters coincide
    always_comb begin
        hit      = 1'b0;
        hit_kind = 2'd0;
        for (int k = 3; k >= 0; k--) begin
            if (i_byte == r_hdr[k] && !r_flags[k]) begin
                hit      = 1'b1;
                hit_kind = 2'(k);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_wpos  = r_wpos;
        n_flags = r_flags;
        o_wr    = '0;
        o_job   = '0;
        if (accept) begin
            if (i_op == OP_RELEASE) begin
                n_flags[i_rel_kind] = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_BODY: begin
                        if (i_byte == CHAR_CR) begin
                            n_phase = PH_TAIL;
                        end else if (r_wpos < r_max_len) begin
                            o_wr.we    = 1'b1;
                            o_wr.first = (r_wpos == 5'd0);
                            o_wr.data  = i_byte;
                            n_wpos     = r_wpos + 5'd1;
                        end else begin
                            n_phase = PH_IDLE;
                            n_kind  = 2'd0;
                        end
                    end
                    PH_TAIL: begin
                        if (i_byte == CHAR_LF) begin
                            n_flags[r_kind] = 1'b1;
                            o_job.valid     = 1'b1;
                            o_job.kind      = r_kind;
                            o_job.len       = r_wpos;
                        end
                        n_phase = PH_IDLE;
                        n_kind  = 2'd0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        if (hit) begin
                            n_kind  = hit_kind;
                            n_wpos  = 5'd0;
                            n_phase = PH_BODY;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= 2'd0;
            r_wpos  <= 5'd0;
            r_flags <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_wpos  <= n_wpos;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr[0]  <= HDR_A_RST;
            r_hdr[1]  <= HDR_B_RST;
            r_hdr[2]  <= HDR_C_RST;
            r_hdr[3]  <= HDR_D_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                REG_HDR_A:   r_hdr[0]  <= i_cfg_wdata;
                REG_HDR_B:   r_hdr[1]  <= i_cfg_wdata;
                REG_HDR_C:   r_hdr[2]  <= i_cfg_wdata;
                REG_HDR_D:   r_hdr[3]  <= i_cfg_wdata;
                REG_MAX_LEN: r_max_len <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

endmodule

### src/fhcpd_back.sv
// Drain back end: payload store, one-entry packet queue, read sequencer
// and output register. Depends on fhcpd_pkg.
`timescale 1ns / 1ps

module fhcpd_back #(
    parameter int unsigned BUFFER_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fhcpd_pkg::t_wr_req i_wr,
    input  fhcpd_pkg::t_job    i_job,
    output logic               o_busy,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_byte,
    output logic [4:0]         o_idx,
    output logic [4:0]         o_len,
    output logic               o_empty,
    output logic               o_last
);
    import fhcpd_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] idx;
        logic [4:0] len;
        logic       empty;
        logic       last;
    } t_meta;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        addr_inc = (a == AW'(BUFFER_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [AW-1:0] r_waddr;
    logic [AW-1:0] waddr;

    logic          r_job_v;
    logic [1:0]    r_job_kind;
    logic [4:0]    r_job_len;

    logic          r_act;
    logic [AW-1:0] r_raddr;
    logic [4:0]    r_ridx;
    logic [4:0]    r_len;
    logic [1:0]    r_kind;

    logic          r_rv;
    t_meta         r_meta;
    logic [7:0]    r_rdata;

    logic          r_ov;
    t_meta         r_ometa;
    logic [7:0]    r_obyte;

    logic          load, issue, take, ridx_last;

    assign load      = r_rv && (!r_ov || i_ready);
    assign issue     = r_act && (!r_rv || load);
    assign take      = r_job_v && !r_act && (!r_rv || load);
    assign ridx_last = (r_ridx + 5'd1 == r_len);
    assign waddr     = i_wr.first ? '0 : r_waddr;
    assign o_busy    = r_job_v || r_act;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[waddr] <= i_wr.data;
        end
        if (issue) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waddr <= '0;
        end else if (i_wr.we) begin
            r_waddr <= addr_inc(waddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
        end else if (i_job.valid) begin
            r_job_v <= 1'b1;
        end else if (take) begin
            r_job_v <= 1'b0;
        end
        if (i_job.valid) begin
            r_job_kind <= i_job.kind;
            r_job_len  <= i_job.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_rv    <= 1'b0;
            r_raddr <= '0;
            r_ridx  <= 5'd0;
        end else begin
            if (take) begin
                if (r_job_len == 5'd0) begin
                    r_rv         <= 1'b1;
                    r_meta.kind  <= r_job_kind;
                    r_meta.idx   <= 5'd0;
                    r_meta.len   <= 5'd0;
                    r_meta.empty <= 1'b1;
                    r_meta.last  <= 1'b1;
                end else begin
                    r_act   <= 1'b1;
                    r_raddr <= '0;
                    r_ridx  <= 5'd0;
                    r_len   <= r_job_len;
                    r_kind  <= r_job_kind;
                    if (load) begin
                        r_rv <= 1'b0;
                    end
                end
            end else if (issue) begin
                r_rv         <= 1'b1;
                r_meta.kind  <= r_kind;
                r_meta.idx   <= r_ridx;
                r_meta.len   <= r_len;
                r_meta.empty <= 1'b0;
                r_meta.last  <= ridx_last;
                r_ridx       <= r_ridx + 5'd1;
                r_raddr      <= addr_inc(r_raddr);
                if (ridx_last) begin
                    r_act <= 1'b0;
                end
            end else if (load) begin
                r_rv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
        if (load) begin
            r_ometa <= r_meta;
            r_obyte <= r_meta.empty ? 8'd0 : r_rdata;
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_ometa.kind;
    assign o_byte  = r_obyte;
    assign o_idx   = r_ometa.idx;
    assign o_len   = r_ometa.len;
    assign o_empty = r_ometa.empty;
    assign o_last  = r_ometa.last;

endmodule

### src/fhcpd_checker.sv
// Port-level checks for the deframer top level, with the bind that attaches
// them. Depends on fhcpd_pkg and four_header_crlf_packet_deframer_unit.
`timescale 1ns / 1ps

module fhcpd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [fhcpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);
    import fhcpd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("empty packet result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[19:15] == 5'd0 && m_axis_tdata[9:2] == 8'd0
            && m_axis_tdata[14:10] == 5'd0)
        else $error("empty packet result carries data");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tlast == (m_axis_tdata[14:10] + 5'd1 == m_axis_tdata[19:15]))
        else $error("last mark does not match byte position");

endmodule

bind four_header_crlf_packet_deframer_unit fhcpd_checker u_fhcpd_checker (.*);

### tb/four_header_crlf_packet_deframer_unit_test.sv
// Self-checking testbench for four_header_crlf_packet_deframer_unit.
// Depends on fhcpd_pkg; drives requests and checks result runs against its own predictor,
// with random idling on both sides and several header and length settings.
`timescale 1ns / 1ps

module four_header_crlf_packet_deframer_unit_test;
    import fhcpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_OFF_LEN   = 400;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_BODY = 2'd1,
        PHASE_TAIL = 2'd2
    } parse_phase_t;

    typedef enum int {
        END_CRLF,
        END_BAD_TAIL,
        END_OVERRUN
    } pkt_end_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [1:0] release_kind;
    } rx_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [4:0] index;
        logic [4:0] length;
        logic       empty;
        logic       last;
    } payload_beat_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wen     = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    four_header_crlf_packet_deframer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state and register copy
    logic [7:0]   hdr_chars [4];
    logic [4:0]   max_len;
    parse_phase_t rx_phase;
    logic [1:0]   rx_kind;
    logic [4:0]   wr_pos;
    logic [7:0]   payload_mem [32];
    logic         kind_ready [4];

    rx_req_t       pending_reqs [$];
    payload_beat_t expected_beats [$];
    rx_req_t       cur_req;
    int            send_gap     = 0;
    int            stall_cnt    = 0;
    int            hold_cnt     = 0;
    bit            hold_off_req = 1'b0;
    int            quiet_cycles = 0;
    int            errors       = 0;
    int            gen_count    = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic emit_payload();
        payload_beat_t b;
        if (wr_pos == 5'd0) begin
            b = '{kind: rx_kind, data: 8'd0, index: 5'd0, length: 5'd0, empty: 1'b1, last: 1'b1};
            expected_beats.push_back(b);
            return;
        end
        for (int i = 0; i < int'(wr_pos); i++) begin
            b.kind   = rx_kind;
            b.data   = payload_mem[i];
            b.index  = 5'(i);
            b.length = wr_pos;
            b.empty  = 1'b0;
            b.last   = (i + 1 == int'(wr_pos));
            expected_beats.push_back(b);
        end
    endtask

    task automatic deframe_request(input rx_req_t req);
        bit opened;
        opened = 1'b0;
        if (req.op == OP_RELEASE) begin
            kind_ready[req.release_kind] = 1'b0;
            return;
        end
        case (rx_phase)
            PHASE_BODY: begin
                if (req.rx_byte == CHAR_CR) begin
                    rx_phase = PHASE_TAIL;
                end else if (wr_pos < max_len) begin
                    payload_mem[wr_pos] = req.rx_byte;
                    wr_pos = wr_pos + 5'd1;
                end else begin
                    rx_phase = PHASE_IDLE;
                    rx_kind  = 2'd0;
                end
            end
            PHASE_TAIL: begin
                if (req.rx_byte == CHAR_LF) begin
                    kind_ready[rx_kind] = 1'b1;
                    emit_payload();
                end
                rx_phase = PHASE_IDLE;
                rx_kind  = 2'd0;
            end
            default: begin
                rx_phase = PHASE_IDLE;
                for (int k = 0; k < 4; k++) begin
                    if (!opened && req.rx_byte == hdr_chars[k] && !kind_ready[k]) begin
                        opened   = 1'b1;
                        rx_kind  = 2'(k);
                        wr_pos   = 5'd0;
                        rx_phase = PHASE_BODY;
                    end
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_request(cur_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {6'd0, cur_req.release_kind, cur_req.rx_byte};
                    s_axis_tuser  <= cur_req.op;
                    s_axis_tvalid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        payload_beat_t e;
        logic          rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $error("result: expected none, got tdata %0h", m_axis_tdata);
                    errors++;
                end else begin
                    e = expected_beats.pop_front();
                    check_field("packet_kind", e.kind, m_axis_tdata[1:0]);
                    check_field("payload_byte", e.data, m_axis_tdata[9:2]);
                    check_field("byte_index", e.index, m_axis_tdata[14:10]);
                    check_field("packet_length", e.length, m_axis_tdata[19:15]);
                    check_field("empty_packet", e.empty, m_axis_tuser);
                    check_field("last", e.last, m_axis_tlast);
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_cnt = HOLD_OFF_LEN;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if ($urandom_range(0, 99) < 25) stall_cnt = idle_len();
            end
            m_axis_tready <= rdy;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wen || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** four_header_crlf_packet_deframer_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_req_t r;
        r.op           = OP_BYTE;
        r.rx_byte      = b;
        r.release_kind = 2'($urandom_range(0, 3));
        pending_reqs.push_back(r);
        gen_count++;
    endtask

    task automatic push_release(input logic [1:0] k);
        rx_req_t r;
        r.op           = OP_RELEASE;
        r.rx_byte      = 8'($urandom_range(0, 255));
        r.release_kind = k;
        pending_reqs.push_back(r);
        gen_count++;
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_CR) b = 8'h0C;
        return b;
    endfunction

    task automatic push_packet(input int k, input int len, input pkt_end_t ending);
        logic [7:0] b;
        push_byte(hdr_chars[k]);
        for (int i = 0; i < len; i++) begin
            push_byte(body_byte());
            if ($urandom_range(0, 99) < 3) push_release(2'($urandom_range(0, 3)));
        end
        case (ending)
            END_CRLF: begin
                push_byte(CHAR_CR);
                push_byte(CHAR_LF);
            end
            END_BAD_TAIL: begin
                push_byte(CHAR_CR);
                b = 8'($urandom_range(0, 255));
                if (b == CHAR_LF) b = 8'h00;
                push_byte(b);
            end
            default: push_byte(body_byte());
        endcase
    endtask

    task automatic random_traffic(input int target);
        int r, k, len, top;
        gen_count = 0;
        while (gen_count < target) begin
            r   = $urandom_range(0, 99);
            k   = $urandom_range(0, 3);
            top = (int'(max_len) < 4) ? int'(max_len) : 4;
            len = ($urandom_range(0, 99) < 75) ? $urandom_range(0, top)
                : ($urandom_range(0, 1) ? int'(max_len) : $urandom_range(0, int'(max_len)));
            if (r < 62) begin
                if ($urandom_range(0, 99) < 80) push_release(2'(k));
                push_packet(k, len, END_CRLF);
            end else if (r < 72) begin
                push_release(2'(k));
            end else if (r < 80) begin
                push_byte(8'($urandom_range(0, 255)));
                gen_count--;
            end else if (r < 90) begin
                push_release(2'(k));
                push_packet(k, len, END_BAD_TAIL);
            end else begin
                push_release(2'(k));
                push_packet(k, int'(max_len), END_OVERRUN);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_HDR_A:   hdr_chars[0] = val;
            REG_HDR_B:   hdr_chars[1] = val;
            REG_HDR_C:   hdr_chars[2] = val;
            REG_HDR_D:   hdr_chars[3] = val;
            REG_MAX_LEN: max_len = val[4:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c, input logic [7:0] d,
                                 input logic [4:0] len);
        write_reg(REG_HDR_A, a);
        write_reg(REG_HDR_B, b);
        write_reg(REG_HDR_C, c);
        write_reg(REG_HDR_D, d);
        write_reg(REG_MAX_LEN, {3'd0, len});
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(negedge i_clk);
    endtask

    // all requests taken, all results seen, then let the drain side settle
    task automatic wait_quiet();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        hdr_chars[0] = HDR_A_RST;
        hdr_chars[1] = HDR_B_RST;
        hdr_chars[2] = HDR_C_RST;
        hdr_chars[3] = HDR_D_RST;
        max_len      = MAX_LEN_RST;
        rx_phase     = PHASE_IDLE;
        rx_kind      = 2'd0;
        wr_pos       = 5'd0;
        for (int k = 0; k < 4; k++) kind_ready[k] = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: noise, one-byte packet, blocked kind, drop after CR,
        // release mid-body, empty packet
        push_byte(8'h00);
        push_byte(8'hFF);
        push_packet(1, 0, END_OVERRUN);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_byte(HDR_B_RST);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CHAR_CR);
        push_byte(CHAR_LF);
        push_packet(1, 1, END_CRLF);
        push_release(2'd1);
        push_byte(HDR_C_RST);
        push_byte(8'h71);
        push_release(2'd2);
        push_byte(CHAR_CR);
        push_byte(8'h78);
        push_packet(3, 0, END_CRLF);
        push_release(2'd3);
        push_release(2'd0);
        random_traffic(60);
        wait_quiet();

        // extremes: odd header characters, shortest payload
        load_settings(8'h00, 8'hFF, CHAR_LF, CHAR_CR, 5'd1);
        random_traffic(50);
        wait_quiet();

        // all headers equal, longest payload, long receiver hold-off
        load_settings(8'h55, 8'h55, 8'h55, 8'h55, 5'd31);
        random_traffic(70);
        hold_off_req = 1'b1;
        wait_quiet();

        load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      5'($urandom_range(1, 31)));
        random_traffic(80);
        wait_quiet();

        if (errors == 0) begin
            $display("** four_header_crlf_packet_deframer_unit: PASSED **");
        end else begin
            $display("** four_header_crlf_packet_deframer_unit: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
src/fhcpd_pkg.sv
src/fhcpd_front.sv
src/fhcpd_back.sv
src/four_header_crlf_packet_deframer_unit.sv
src/fhcpd_checker.sv
tb/four_header_crlf_packet_deframer_unit_test.sv
